>>> rtl/apcm_pkg.sv
// ---------------------------------------------------------------------------
// apcm_pkg
// Types, constants and arithmetic helpers for the palette color matcher.
// ---------------------------------------------------------------------------
package apcm_pkg;

   localparam int unsigned BasicCount = 16;
   localparam int unsigned BasicLevels = 4;
   localparam int unsigned CubeLevels = 6;
   localparam int unsigned GrayCount = 24;

   localparam logic [7:0] TOL_RESET = 8'd3;

   typedef enum logic [1:0] {
      MODE_BASIC  = 2'd0,
      MODE_EXT    = 2'd1,
      MODE_DIRECT = 2'd2
   } color_mode_type;

   // basic level codes: 0 -> 0, 1 -> 128, 2 -> 192, 3 -> 255
   localparam logic [7:0] BASIC_LEVEL [BasicLevels] = '{8'd0, 8'd128, 8'd192, 8'd255};

   // basic sixteen as level codes, r in [5:4], g in [3:2], b in [1:0]
   localparam logic [5:0] BASIC16 [BasicCount] = '{
      6'b00_00_00, 6'b01_00_00, 6'b00_01_00, 6'b01_01_00,
      6'b00_00_01, 6'b01_00_01, 6'b00_01_01, 6'b10_10_10,
      6'b01_01_01, 6'b11_00_00, 6'b00_11_00, 6'b11_11_00,
      6'b00_00_11, 6'b11_00_11, 6'b00_11_11, 6'b11_11_11
   };

   localparam logic [7:0] CUBE_LEVEL [CubeLevels] =
      '{8'd0, 8'd95, 8'd135, 8'd175, 8'd215, 8'd255};

   localparam int unsigned GrayBase = 8;
   localparam int unsigned GrayStep = 10;
   localparam int unsigned CubeFirst = 16;
   localparam int unsigned GrayFirst = 232;

   // per-channel within-tolerance flags for every palette level
   typedef struct packed {
      logic [BasicLevels-1:0] basic_r;
      logic [BasicLevels-1:0] basic_g;
      logic [BasicLevels-1:0] basic_b;
      logic [CubeLevels-1:0]  cube_r;
      logic [CubeLevels-1:0]  cube_g;
      logic [CubeLevels-1:0]  cube_b;
      logic [GrayCount-1:0]   gray_r;
      logic [GrayCount-1:0]   gray_g;
      logic [GrayCount-1:0]   gray_b;
   } flags_type;

   function automatic logic [7:0] gray_level(input int unsigned k);
      return 8'(GrayBase + GrayStep * k);
   endfunction

   // (v*31+127)/255; x/255 == (x + 1 + (x >> 8)) >> 8 for x < 65535
   function automatic logic [4:0] quant5(input logic [7:0] v);
      logic [12:0] x;
      logic [13:0] s;
      x = 13'(v) * 13'd31 + 13'd127;
      s = 14'(x) + 14'd1 + 14'(x >> 8);
      return 5'(s >> 8);
   endfunction

   function automatic logic [5:0] quant6(input logic [7:0] v);
      logic [13:0] x;
      logic [14:0] s;
      x = 14'(v) * 14'd63 + 14'd127;
      s = 15'(x) + 15'd1 + 15'(x >> 8);
      return 6'(s >> 8);
   endfunction

   // (q*255+15)/31 via reciprocal 33826 / 2^20, exact for this range
   function automatic logic [7:0] expand5(input logic [4:0] q);
      logic [12:0] x;
      logic [28:0] p;
      x = 13'(q) * 13'd255 + 13'd15;
      p = 29'(x) * 29'd33826;
      return 8'(p >> 20);
   endfunction

   // (q*255+31)/63 via reciprocal 33289 / 2^21
   function automatic logic [7:0] expand6(input logic [5:0] q);
      logic [13:0] x;
      logic [29:0] p;
      x = 14'(q) * 14'd255 + 14'd31;
      p = 30'(x) * 30'd33289;
      return 8'(p >> 21);
   endfunction

   function automatic logic near(input logic [7:0] c, input logic [7:0] lvl,
                                 input logic [7:0] tol);
      logic [7:0] d;
      d = (c >= lvl) ? (c - lvl) : (lvl - c);
      return d <= tol;
   endfunction

endpackage

>>> rtl/apcm_if.sv
// ---------------------------------------------------------------------------
// apcm channel interfaces
// Pixel request channel and match response channel, valid/ready.
// ---------------------------------------------------------------------------
interface apcm_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] red_in;
   logic [7:0] green_in;
   logic [7:0] blue_in;

   modport source (output valid, output red_in, output green_in, output blue_in,
                   input ready);
   modport sink   (input valid, input red_in, input green_in, input blue_in,
                   output ready);
endinterface

interface apcm_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  color_mode;
   logic [7:0]  palette_index;
   logic [15:0] packed_565;

   modport source (output valid, output color_mode, output palette_index,
                   output packed_565, input ready);
   modport sink   (input valid, input color_mode, input palette_index,
                   input packed_565, output ready);
endinterface

>>> rtl/apcm_classify.sv
// ---------------------------------------------------------------------------
// apcm_classify
// First-match priority selection over the level flags: basic sixteen,
// then cube, then gray ramp, else direct color.
// ---------------------------------------------------------------------------
module apcm_classify
   import apcm_pkg::*;
(
   input  flags_type      flags,
   output color_mode_type mode,
   output logic [7:0]     index
);

   logic                 basic_hit;
   logic [3:0]           basic_idx;
   logic [2:0]           cube_ir, cube_ig, cube_ib;
   logic                 cube_hit;
   logic [GrayCount-1:0] gray_all;
   logic                 gray_hit;
   logic [4:0]           gray_idx;

   always_comb begin
      basic_hit = 1'b0;
      basic_idx = '0;
      for (int i = BasicCount - 1; i >= 0; i--) begin
         if (flags.basic_r[BASIC16[i][5:4]] && flags.basic_g[BASIC16[i][3:2]] &&
             flags.basic_b[BASIC16[i][1:0]]) begin
            basic_hit = 1'b1;
            basic_idx = 4'(i);
         end
      end
   end

   // channels are independent, so the lowest cube index takes the lowest
   // matching level on each channel
   always_comb begin
      cube_ir = '0;
      cube_ig = '0;
      cube_ib = '0;
      for (int i = CubeLevels - 1; i >= 0; i--) begin
         if (flags.cube_r[i]) cube_ir = 3'(i);
         if (flags.cube_g[i]) cube_ig = 3'(i);
         if (flags.cube_b[i]) cube_ib = 3'(i);
      end
      cube_hit = (|flags.cube_r) && (|flags.cube_g) && (|flags.cube_b);
   end

   always_comb begin
      gray_all = flags.gray_r & flags.gray_g & flags.gray_b;
      gray_hit = |gray_all;
      gray_idx = '0;
      for (int i = GrayCount - 1; i >= 0; i--) begin
         if (gray_all[i]) gray_idx = 5'(i);
      end
   end

   always_comb begin
      if (basic_hit) begin
         mode  = MODE_BASIC;
         index = {4'd0, basic_idx};
      end else if (cube_hit) begin
         mode  = MODE_EXT;
         index = 8'(CubeFirst + 36 * int'(cube_ir) + 6 * int'(cube_ig) + int'(cube_ib));
      end else if (gray_hit) begin
         mode  = MODE_EXT;
         index = 8'(GrayFirst + int'(gray_idx));
      end else begin
         mode  = MODE_DIRECT;
         index = '0;
      end
   end

endmodule

>>> rtl/ansi_palette_color_match.sv
// ---------------------------------------------------------------------------
// ansi_palette_color_match
// Rounds an RGB888 pixel to RGB565 and maps it to a 256-entry palette code.
// ---------------------------------------------------------------------------
// Usage:
//   req_bus carries one pixel per beat (red_in, green_in, blue_in).
//   rsp_bus returns one beat per pixel: color_mode, palette_index and the
//   rounded packed_565, in input order.
//   csr_write_en/csr_write_data load the match tolerance; write only while
//   no pixel is in flight.
// Throughput: one pixel per cycle; the five-stage pipeline (input, 565
//   quantize, re-expand, level compare, priority select) takes a new beat
//   every cycle while the response side keeps taking.
// Stall: each stage holds its beat while the one after it is full and
//   stalled; empty stages keep filling, and req_bus.ready drops only once
//   the first stage is full and blocked.
// Reset: clears all stage valid bits and sets the tolerance to 3.
// ---------------------------------------------------------------------------
module ansi_palette_color_match
   import apcm_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   apcm_req_if.sink        req_bus,
   apcm_rsp_if.source      rsp_bus,
   input  logic            csr_write_en,
   input  logic [7:0]      csr_write_data
);

   logic [7:0] tol_ff;

   // stage enables, back to front
   logic en1, en2, en3, en4, en5;

   logic       s1_valid_ff;
   logic [7:0] s1_red_ff, s1_green_ff, s1_blue_ff;

   logic       s2_valid_ff;
   logic [4:0] s2_r5_ff, s2_b5_ff, s2_r5_in, s2_b5_in;
   logic [5:0] s2_g6_ff, s2_g6_in;

   logic        s3_valid_ff;
   logic [7:0]  s3_rv_ff, s3_gv_ff, s3_bv_ff, s3_rv_in, s3_gv_in, s3_bv_in;
   logic [15:0] s3_packed_ff;

   logic        s4_valid_ff;
   flags_type   s4_flags_ff, s4_flags_in;
   logic [15:0] s4_packed_ff;

   logic           s5_valid_ff;
   color_mode_type s5_mode_ff, s5_mode_in;
   logic [7:0]     s5_index_ff, s5_index_in;
   logic [15:0]    s5_packed_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= TOL_RESET;
      end else if (csr_write_en) begin
         tol_ff <= csr_write_data;
      end
   end

   always_comb begin
      en5 = !s5_valid_ff || rsp_bus.ready;
      en4 = !s4_valid_ff || en5;
      en3 = !s3_valid_ff || en4;
      en2 = !s2_valid_ff || en3;
      en1 = !s1_valid_ff || en2;
   end

   assign req_bus.ready = en1;

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
      end else begin
         if (en1) s1_valid_ff <= req_bus.valid;
         if (en2) s2_valid_ff <= s1_valid_ff;
         if (en3) s3_valid_ff <= s2_valid_ff;
         if (en4) s4_valid_ff <= s3_valid_ff;
         if (en5) s5_valid_ff <= s4_valid_ff;
      end
   end

   // stage 2: round to 565
   assign s2_r5_in = quant5(s1_red_ff);
   assign s2_g6_in = quant6(s1_green_ff);
   assign s2_b5_in = quant5(s1_blue_ff);

   // stage 3: expand back to 8 bits
   assign s3_rv_in = expand5(s2_r5_ff);
   assign s3_gv_in = expand6(s2_g6_ff);
   assign s3_bv_in = expand5(s2_b5_ff);

   // stage 4: per-channel tolerance compare against every level
   always_comb begin
      for (int i = 0; i < BasicLevels; i++) begin
         s4_flags_in.basic_r[i] = near(s3_rv_ff, BASIC_LEVEL[i], tol_ff);
         s4_flags_in.basic_g[i] = near(s3_gv_ff, BASIC_LEVEL[i], tol_ff);
         s4_flags_in.basic_b[i] = near(s3_bv_ff, BASIC_LEVEL[i], tol_ff);
      end
      for (int i = 0; i < CubeLevels; i++) begin
         s4_flags_in.cube_r[i] = near(s3_rv_ff, CUBE_LEVEL[i], tol_ff);
         s4_flags_in.cube_g[i] = near(s3_gv_ff, CUBE_LEVEL[i], tol_ff);
         s4_flags_in.cube_b[i] = near(s3_bv_ff, CUBE_LEVEL[i], tol_ff);
      end
      for (int i = 0; i < GrayCount; i++) begin
         s4_flags_in.gray_r[i] = near(s3_rv_ff, gray_level(i), tol_ff);
         s4_flags_in.gray_g[i] = near(s3_gv_ff, gray_level(i), tol_ff);
         s4_flags_in.gray_b[i] = near(s3_bv_ff, gray_level(i), tol_ff);
      end
   end

   // stage 5: first-match select
   apcm_classify u_classify (
      .flags (s4_flags_ff),
      .mode  (s5_mode_in),
      .index (s5_index_in)
   );

   // payload
   always_ff @(posedge clock) begin
      if (en1) begin
         s1_red_ff   <= req_bus.red_in;
         s1_green_ff <= req_bus.green_in;
         s1_blue_ff  <= req_bus.blue_in;
      end
      if (en2) begin
         s2_r5_ff <= s2_r5_in;
         s2_g6_ff <= s2_g6_in;
         s2_b5_ff <= s2_b5_in;
      end
      if (en3) begin
         s3_rv_ff     <= s3_rv_in;
         s3_gv_ff     <= s3_gv_in;
         s3_bv_ff     <= s3_bv_in;
         s3_packed_ff <= {s2_r5_ff, s2_g6_ff, s2_b5_ff};
      end
      if (en4) begin
         s4_flags_ff  <= s4_flags_in;
         s4_packed_ff <= s3_packed_ff;
      end
      if (en5) begin
         s5_mode_ff   <= s5_mode_in;
         s5_index_ff  <= s5_index_in;
         s5_packed_ff <= s4_packed_ff;
      end
   end

   assign rsp_bus.valid         = s5_valid_ff;
   assign rsp_bus.color_mode    = s5_mode_ff;
   assign rsp_bus.palette_index = s5_index_ff;
   assign rsp_bus.packed_565    = s5_packed_ff;

   a_direct_zero_index: assert property (@(posedge clock) disable iff (reset)
      s5_valid_ff && s5_mode_ff == MODE_DIRECT |-> s5_index_ff == 8'd0)
      else $error("direct color beat with nonzero palette index");

   a_basic_range: assert property (@(posedge clock) disable iff (reset)
      s5_valid_ff && s5_mode_ff == MODE_BASIC |-> s5_index_ff < 8'd16)
      else $error("basic mode index outside the sixteen");

   a_ext_range: assert property (@(posedge clock) disable iff (reset)
      s5_valid_ff && s5_mode_ff == MODE_EXT |-> s5_index_ff >= 8'd16)
      else $error("extended mode index inside the basic sixteen");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !s1_valid_ff && !s5_valid_ff && tol_ff == TOL_RESET)
      else $error("pipeline not empty after reset");

endmodule

>>> dv/tb_ansi_palette_color_match.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_ansi_palette_color_match
// Drives pixel beats into the palette matcher under random bursts and
// response stalls, predicts each response from the pixel and the current
// tolerance, and checks every response beat in order. The tolerance is
// rewritten between phases, only after the pipeline has drained.
// ---------------------------------------------------------------------------
module tb_ansi_palette_color_match
   import apcm_pkg::*;
();

   localparam int DRAIN_CYCLES = 8;       // pipeline latency plus margin
   localparam int CYCLE_LIMIT  = 300000;
   localparam int PHASE_PIXELS = 150;

   typedef enum logic [1:0] {
      STIM_PIXEL,
      STIM_TOL,
      STIM_DRAIN
   } stim_kind_type;

   typedef enum logic [1:0] {
      RX_OPEN,
      RX_LIGHT,
      RX_HEAVY,
      RX_PERIODIC
   } rx_pattern_type;

   typedef struct {
      stim_kind_type kind;
      logic [7:0]    red;
      logic [7:0]    green;
      logic [7:0]    blue;
      logic [7:0]    tol;
   } stim_type;

   typedef struct {
      color_mode_type mode;
      logic [7:0]     index;
      logic [15:0]    rgb565;
   } color_match_type;

   localparam logic [23:0] BASIC_RGB [16] = '{
      24'h000000, 24'h800000, 24'h008000, 24'h808000,
      24'h000080, 24'h800080, 24'h008080, 24'hC0C0C0,
      24'h808080, 24'hFF0000, 24'h00FF00, 24'hFFFF00,
      24'h0000FF, 24'hFF00FF, 24'h00FFFF, 24'hFFFFFF
   };
   localparam logic [7:0] CUBE_STEP [6] = '{8'd0, 8'd95, 8'd135, 8'd175, 8'd215, 8'd255};

   logic clock;
   logic reset;
   logic csr_write_en;
   logic [7:0] csr_write_data;

   apcm_req_if req_bus ();
   apcm_rsp_if rsp_bus ();

   ansi_palette_color_match i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_bus        (req_bus),
      .rsp_bus        (rsp_bus),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   stim_type        pixel_plan[$];
   color_match_type expected_colors[$];
   logic [7:0]      tol_model = TOL_RESET;
   int              pixels_sent;
   int              pixels_matched;
   int              gap_left;
   int              burst_left;
   int              settle_left;
   int              fail_count;
   int              cycle_count;
   rx_pattern_type  rx_mode;
   int              rx_left;

   // color of palette entry idx as {r, g, b}
   function automatic logic [23:0] palette_rgb(input int unsigned idx);
      int unsigned c;
      logic [7:0]  v;
      if (idx < 16) begin
         return BASIC_RGB[idx];
      end
      if (idx < 232) begin
         c = idx - 16;
         return {CUBE_STEP[c / 36], CUBE_STEP[(c / 6) % 6], CUBE_STEP[c % 6]};
      end
      v = 8'(8 + 10 * (idx - 232));
      return {v, v, v};
   endfunction

   // 565 rounding, re-expansion, then first palette entry within tolerance
   function automatic color_match_type match_pixel(input logic [7:0] r,
                                                   input logic [7:0] g,
                                                   input logic [7:0] b,
                                                   input logic [7:0] tol);
      color_match_type res;
      int unsigned     q_r, q_g, q_b;
      int              e_r, e_g, e_b;
      int              d, worst;
      logic [23:0]     pal;
      q_r = (32'(r) * 31 + 127) / 255;
      q_g = (32'(g) * 63 + 127) / 255;
      q_b = (32'(b) * 31 + 127) / 255;
      e_r = (q_r * 255 + 15) / 31;
      e_g = (q_g * 255 + 31) / 63;
      e_b = (q_b * 255 + 15) / 31;
      res.mode   = MODE_DIRECT;
      res.index  = 8'd0;
      res.rgb565 = {5'(q_r), 6'(q_g), 5'(q_b)};
      for (int idx = 0; idx < 256; idx++) begin
         pal = palette_rgb(idx);
         worst = e_r - int'(pal[23:16]);
         if (worst < 0) worst = -worst;
         d = e_g - int'(pal[15:8]);
         if (d < 0) d = -d;
         if (d > worst) worst = d;
         d = e_b - int'(pal[7:0]);
         if (d < 0) d = -d;
         if (d > worst) worst = d;
         if (worst <= int'(tol)) begin
            res.mode  = (idx < 16) ? MODE_BASIC : MODE_EXT;
            res.index = 8'(idx);
            break;
         end
      end
      return res;
   endfunction

   function automatic logic [7:0] jitter(input logic [7:0] v, input int span);
      int x;
      x = int'(v) + $urandom_range(0, 2 * span) - span;
      if (x < 0) x = 0;
      if (x > 255) x = 255;
      return 8'(x);
   endfunction

   function automatic stim_type random_pixel();
      stim_type    s;
      logic [23:0] pal;
      int          span;
      s.kind = STIM_PIXEL;
      s.tol  = 8'd0;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: begin
            s.red   = 8'($urandom);
            s.green = 8'($urandom);
            s.blue  = 8'($urandom);
         end
         8: begin
            pal = BASIC_RGB[$urandom_range(0, 15)];
            {s.red, s.green, s.blue} = pal;
         end
         default: begin
            // near a cube or gray entry, so the extended search gets hit
            pal  = palette_rgb($urandom_range(16, 255));
            span = $urandom_range(0, 8);
            s.red   = jitter(pal[23:16], span);
            s.green = jitter(pal[15:8], span);
            s.blue  = jitter(pal[7:0], span);
         end
      endcase
      return s;
   endfunction

   task automatic add_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
      pixel_plan.push_back('{STIM_PIXEL, r, g, b, 8'd0});
   endtask

   task automatic add_control(input stim_kind_type kind, input logic [7:0] tol);
      pixel_plan.push_back('{kind, 8'd0, 8'd0, 8'd0, tol});
   endtask

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // request driver
   always @(posedge clock) begin
      logic       drive_valid;
      logic [7:0] drive_r, drive_g, drive_b;
      logic       wr_en;
      logic [7:0] wr_data;
      int         sent_now;
      if (reset) begin
         req_bus.valid <= 1'b0;
         csr_write_en  <= 1'b0;
         pixels_sent   <= 0;
         gap_left      <= 0;
         burst_left    <= 1;
         settle_left   <= 0;
      end else begin
         drive_valid = req_bus.valid;
         drive_r     = req_bus.red_in;
         drive_g     = req_bus.green_in;
         drive_b     = req_bus.blue_in;
         wr_en       = 1'b0;
         wr_data     = csr_write_data;
         sent_now    = pixels_sent;
         if (req_bus.valid && req_bus.ready) begin
            expected_colors.push_back(match_pixel(req_bus.red_in, req_bus.green_in,
                                                  req_bus.blue_in, tol_model));
            sent_now++;
            drive_valid = 1'b0;
         end
         if (!drive_valid && pixel_plan.size() != 0) begin
            if (pixel_plan[0].kind != STIM_PIXEL) begin
               // tolerance writes and pauses wait for an empty pipeline
               if (sent_now != pixels_matched) begin
                  settle_left <= DRAIN_CYCLES;
               end else if (settle_left != 0) begin
                  settle_left <= settle_left - 1;
               end else begin
                  if (pixel_plan[0].kind == STIM_TOL) begin
                     wr_en     = 1'b1;
                     wr_data   = pixel_plan[0].tol;
                     tol_model = pixel_plan[0].tol;
                  end
                  void'(pixel_plan.pop_front());
                  settle_left <= 2;
               end
            end else if (settle_left != 0) begin
               settle_left <= settle_left - 1;
            end else if (gap_left != 0) begin
               gap_left <= gap_left - 1;
            end else begin
               drive_valid = 1'b1;
               drive_r     = pixel_plan[0].red;
               drive_g     = pixel_plan[0].green;
               drive_b     = pixel_plan[0].blue;
               void'(pixel_plan.pop_front());
               if (burst_left <= 1) begin
                  burst_left <= ($urandom_range(0, 7) == 0) ? 100 : $urandom_range(1, 12);
                  gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
               end else begin
                  burst_left <= burst_left - 1;
               end
            end
         end
         pixels_sent      <= sent_now;
         req_bus.valid    <= drive_valid;
         req_bus.red_in   <= drive_r;
         req_bus.green_in <= drive_g;
         req_bus.blue_in  <= drive_b;
         csr_write_en     <= wr_en;
         csr_write_data   <= wr_data;
      end
   end

   // response monitor and stall pattern
   always @(posedge clock) begin
      color_match_type want;
      logic            rx_ready;
      if (reset) begin
         rsp_bus.ready  <= 1'b0;
         pixels_matched <= 0;
         rx_mode        <= RX_OPEN;
         rx_left        <= 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            pixels_matched <= pixels_matched + 1;
            if (expected_colors.size() == 0) begin
               $error("response beat with no pixel outstanding");
               fail_count++;
            end else begin
               want = expected_colors.pop_front();
               if (rsp_bus.color_mode !== want.mode) begin
                  $error("color_mode: expected %0d, got %0d", want.mode, rsp_bus.color_mode);
                  fail_count++;
               end
               if (rsp_bus.palette_index !== want.index) begin
                  $error("palette_index: expected %0d, got %0d", want.index,
                         rsp_bus.palette_index);
                  fail_count++;
               end
               if (rsp_bus.packed_565 !== want.rgb565) begin
                  $error("packed_565: expected 0x%04h, got 0x%04h", want.rgb565,
                         rsp_bus.packed_565);
                  fail_count++;
               end
            end
         end
         if (rx_left == 0) begin
            rx_mode <= rx_pattern_type'($urandom_range(0, 3));
            rx_left <= $urandom_range(20, 200);
         end else begin
            rx_left <= rx_left - 1;
         end
         case (rx_mode)
            RX_OPEN:  rx_ready = 1'b1;
            RX_LIGHT: rx_ready = ($urandom_range(0, 3) != 0);
            RX_HEAVY: rx_ready = ($urandom_range(0, 1) != 0);
            default:  rx_ready = (rx_left % 7) > 2;
         endcase
         rsp_bus.ready <= rx_ready;
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin
      logic [7:0] phase_tol [8];
      reset            = 1'b1;
      req_bus.valid    = 1'b0;
      req_bus.red_in   = 8'd0;
      req_bus.green_in = 8'd0;
      req_bus.blue_in  = 8'd0;
      rsp_bus.ready    = 1'b0;
      csr_write_en     = 1'b0;
      csr_write_data   = 8'd0;

      // directed, reset tolerance
      add_pixel(8'd0, 8'd0, 8'd0);
      add_pixel(8'd255, 8'd255, 8'd255);
      add_pixel(8'd255, 8'd0, 8'd0);
      add_pixel(8'd0, 8'd255, 8'd0);
      add_pixel(8'd0, 8'd0, 8'd255);
      add_pixel(8'd128, 8'd128, 8'd128);
      add_pixel(8'd192, 8'd192, 8'd192);
      add_pixel(8'd95, 8'd135, 8'd175);
      add_pixel(8'd215, 8'd255, 8'd95);
      add_pixel(8'd8, 8'd8, 8'd8);
      add_pixel(8'd238, 8'd238, 8'd238);
      add_pixel(8'd10, 8'd200, 8'd90);    // falls to direct color
      add_pixel(8'hAA, 8'h55, 8'hAA);
      add_pixel(8'h55, 8'hAA, 8'h55);
      add_pixel(8'd127, 8'd128, 8'd129);
      // exact tolerance
      add_control(STIM_TOL, 8'd0);
      add_pixel(8'd0, 8'd0, 8'd0);
      add_pixel(8'd255, 8'd255, 8'd255);
      add_pixel(8'd95, 8'd95, 8'd95);
      add_pixel(8'd128, 8'd0, 8'd128);
      // widest tolerance: everything lands on basic black
      add_control(STIM_TOL, 8'd255);
      add_pixel(8'd77, 8'd150, 8'd33);
      add_pixel(8'd255, 8'd255, 8'd255);
      add_pixel(8'd0, 8'd255, 8'd0);

      phase_tol = '{8'd0, 8'd255, 8'd1, 8'd3, 8'd12, 8'($urandom), 8'($urandom_range(0, 30)),
                    8'd6};
      for (int p = 0; p < 8; p++) begin
         add_control(STIM_TOL, phase_tol[p]);
         for (int n = 0; n < PHASE_PIXELS; n++) begin
            if (n == PHASE_PIXELS / 2) add_control(STIM_DRAIN, 8'd0);
            pixel_plan.push_back(random_pixel());
         end
      end

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // sample on the falling edge so the driver's updates have settled
      while (pixel_plan.size() != 0 || req_bus.valid || pixels_sent != pixels_matched)
         @(negedge clock);
      repeat (2 * DRAIN_CYCLES) @(posedge clock);
      if (expected_colors.size() != 0) begin
         $error("%0d responses never arrived", expected_colors.size());
         fail_count++;
      end
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

>>> files.f
rtl/apcm_pkg.sv
rtl/apcm_if.sv
rtl/apcm_classify.sv
rtl/ansi_palette_color_match.sv
dv/tb_ansi_palette_color_match.sv
